// File: hw/rtl/rvil_pkg.sv
// shared constants and types for the ray/voxel intersection length core
package rvil_pkg;

  localparam int GRID_NX_DEF = 512;
  localparam int GRID_NY_DEF = 512;
  localparam int GRID_NZ_DEF = 512;

  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 31;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 40;
  localparam int STAT_W     = 2;
  localparam int PROD_W     = IDX_W + SIZE_W;   // index times voxel size
  localparam int NUM_W      = 44;               // plane offset from the start point
  localparam int FRAC_W     = 33;               // Q0.32 with room for exactly one
  localparam int RAD_W      = 66;
  localparam int ROOT_W     = 33;
  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 33;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [SIZE_W-1:0] VSZ_RST = SIZE_W'(65536);
  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {(FRAC_W-1){1'b0}}};

  typedef enum logic [STAT_W-1:0] {
    STAT_HIT  = 2'd0,
    STAT_MISS = 2'd1,
    STAT_OOB  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_VSZ_X = 3'd0,
    REG_VSZ_Y = 3'd1,
    REG_VSZ_Z = 3'd2,
    REG_ORG_X = 3'd3,
    REG_ORG_Y = 3'd4,
    REG_ORG_Z = 3'd5
  } reg_idx_e;

  // flags that travel alongside the dividers
  typedef struct packed {
    logic       oob;
    logic       fail;
    logic [2:0] par;
    logic [5:0] zero;
    logic [5:0] one;
  } side_t;

endpackage

// File: hw/rtl/ray_voxel_intersection_length_core.sv
// ray/voxel intersection length core: top level with config registers and pipeline
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | in        | in_valid_i / in_stall_o   | ray_start_*, ray_end_*, voxel_index_*
//  out     | out       | out_valid_o / out_stall_i | segment_length_o, status_o
//  config  | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// one transfer per cycle in, one per cycle out while out_stall_i is low; a transfer
// passes the 32-stage divider, then intersect, overlap, multiply and output stages
// reset clears the valid bits and loads the register reset values
// each stage holds while the stages behind it are full and the output is stalled,
// so bubbles close up and the input keeps taking transfers while a result waits
module ray_voxel_intersection_length_core #(
  parameter int GRID_NX = rvil_pkg::GRID_NX_DEF,
  parameter int GRID_NY = rvil_pkg::GRID_NY_DEF,
  parameter int GRID_NZ = rvil_pkg::GRID_NZ_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rvil_pkg::PADDR_W-1:0]       paddr,
  input  logic [rvil_pkg::PDATA_W-1:0]       pwdata,
  output logic [rvil_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_start_x_i,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_start_y_i,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_start_z_i,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_end_x_i,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_end_y_i,
  input  logic signed [rvil_pkg::COORD_W-1:0] ray_end_z_i,
  input  logic [rvil_pkg::IDX_W-1:0]         voxel_index_x_i,
  input  logic [rvil_pkg::IDX_W-1:0]         voxel_index_y_i,
  input  logic [rvil_pkg::IDX_W-1:0]         voxel_index_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rvil_pkg::LEN_W-1:0]         segment_length_o,
  output logic [rvil_pkg::STAT_W-1:0]        status_o
);
  import rvil_pkg::*;

  localparam int S_DIV   = 4;
  localparam int S_SQRT  = S_DIV + 1;
  localparam int S_LOHI  = S_DIV + DIV_STEPS;
  localparam int S_DELTA = S_LOHI + 1;
  localparam int S_MUL   = S_DELTA + 1;
  localparam int S_OUT   = S_MUL + 1;
  localparam int NSTG    = S_OUT + 1;

  // ---------------- configuration registers ----------------
  logic [SIZE_W-1:0]  vsz_q [3];
  logic [COORD_W-1:0] org_q [3];
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        vsz_q[a] <= VSZ_RST;
        org_q[a] <= '0;
      end
    end else if (wr) begin
      case (reg_idx_e'(paddr[PADDR_W-1:2]))
        REG_VSZ_X: vsz_q[0] <= pwdata[SIZE_W-1:0];
        REG_VSZ_Y: vsz_q[1] <= pwdata[SIZE_W-1:0];
        REG_VSZ_Z: vsz_q[2] <= pwdata[SIZE_W-1:0];
        REG_ORG_X: org_q[0] <= pwdata;
        REG_ORG_Y: org_q[1] <= pwdata;
        REG_ORG_Z: org_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[PADDR_W-1:2]))
      REG_VSZ_X: prdata = {1'b0, vsz_q[0]};
      REG_VSZ_Y: prdata = {1'b0, vsz_q[1]};
      REG_VSZ_Z: prdata = {1'b0, vsz_q[2]};
      REG_ORG_X: prdata = org_q[0];
      REG_ORG_Y: prdata = org_q[1];
      REG_ORG_Z: prdata = org_q[2];
      default:   prdata = '0;
    endcase
  end

  // ---------------- stage control ----------------
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   ld;

  assign ld[NSTG] = !out_stall_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_ld
    // a stage loads when the output drains or some stage from here on is empty
    assign ld[k] = ld[NSTG] || !(&v_q[NSTG-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (ld[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NSTG-1];

  // ---------------- per-axis inputs ----------------
  logic [COORD_W-1:0] p1 [3];
  logic [COORD_W-1:0] p2 [3];
  logic [IDX_W-1:0]   idx [3];

  assign p1[0]  = ray_start_x_i;
  assign p1[1]  = ray_start_y_i;
  assign p1[2]  = ray_start_z_i;
  assign p2[0]  = ray_end_x_i;
  assign p2[1]  = ray_end_y_i;
  assign p2[2]  = ray_end_z_i;
  assign idx[0] = voxel_index_x_i;
  assign idx[1] = voxel_index_y_i;
  assign idx[2] = voxel_index_z_i;

  // ---------------- stage 0: differences and plane products ----------------
  logic [COORD_W:0]   den0_q [3];
  logic [COORD_W:0]   bp0_q  [3];
  logic [PROD_W-1:0]  nd0_q  [3];
  logic               oob0_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int a = 0; a < 3; a++) begin
        den0_q[a] <= {p2[a][COORD_W-1], p2[a]} - {p1[a][COORD_W-1], p1[a]};
        bp0_q[a]  <= {org_q[a][COORD_W-1], org_q[a]} - {p1[a][COORD_W-1], p1[a]};
        nd0_q[a]  <= {{SIZE_W{1'b0}}, idx[a]} * {{IDX_W{1'b0}}, vsz_q[a]};
      end
      oob0_q <= ({1'b0, voxel_index_x_i} >= (IDX_W+1)'(GRID_NX)) ||
                ({1'b0, voxel_index_y_i} >= (IDX_W+1)'(GRID_NY)) ||
                ({1'b0, voxel_index_z_i} >= (IDX_W+1)'(GRID_NZ));
    end
  end

  // ---------------- stage 1: plane offsets, parallel-axis test ----------------
  logic [NUM_W-1:0]  num0_c [3];
  logic [NUM_W-1:0]  num1_c [3];
  logic [2:0]        par_c;
  logic [2:0]        miss_c;
  logic [NUM_W-1:0]  num1_q [6];
  logic [COORD_W:0]  den1_q [3];
  logic [2:0]        par1_q;
  logic              fail1_q, oob1_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num0_c[a] = {{(NUM_W-COORD_W-1){bp0_q[a][COORD_W]}}, bp0_q[a]} +
                  {{(NUM_W-PROD_W){1'b0}}, nd0_q[a]};
      num1_c[a] = num0_c[a] + {{(NUM_W-SIZE_W){1'b0}}, vsz_q[a]};
      par_c[a]  = (den0_q[a] == '0);
      miss_c[a] = par_c[a] && (!num0_c[a][NUM_W-1] || num1_c[a][NUM_W-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int a = 0; a < 3; a++) begin
        num1_q[2*a]   <= num0_c[a];
        num1_q[2*a+1] <= num1_c[a];
        den1_q[a]     <= den0_q[a];
      end
      par1_q  <= par_c;
      fail1_q <= (&par_c) || (|miss_c);
      oob1_q  <= oob0_q;
    end
  end

  // ---------------- stage 2: make the denominator positive ----------------
  logic [NUM_W-1:0]   num2_q [6];
  logic [COORD_W-1:0] den2_q [3];
  logic [2:0]         par2_q;
  logic               fail2_q, oob2_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int f = 0; f < 6; f++) begin
        num2_q[f] <= den1_q[f/2][COORD_W] ? (NUM_W'(0) - num1_q[f]) : num1_q[f];
      end
      for (int a = 0; a < 3; a++) begin
        den2_q[a] <= den1_q[a][COORD_W] ? COORD_W'((COORD_W+1)'(0) - den1_q[a])
                                        : den1_q[a][COORD_W-1:0];
      end
      par2_q  <= par1_q;
      fail2_q <= fail1_q;
      oob2_q  <= oob1_q;
    end
  end

  // ---------------- stage 3: classify fractions, square the extents ----------------
  logic [5:0]          zero_c, one_c;
  logic [COORD_W-1:0]  numt3_q [6];
  logic [COORD_W-1:0]  den3_q  [3];
  logic [2*COORD_W-1:0] sq3_q  [3];
  side_t               side3_q;

  always_comb begin
    for (int f = 0; f < 6; f++) begin
      zero_c[f] = num2_q[f][NUM_W-1] || (num2_q[f] == '0);
      one_c[f]  = !zero_c[f] &&
                  (num2_q[f] >= {{(NUM_W-COORD_W){1'b0}}, den2_q[f/2]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int f = 0; f < 6; f++) numt3_q[f] <= num2_q[f][COORD_W-1:0];
      for (int a = 0; a < 3; a++) begin
        den3_q[a] <= den2_q[a];
        sq3_q[a]  <= {{COORD_W{1'b0}}, den2_q[a]} * {{COORD_W{1'b0}}, den2_q[a]};
      end
      side3_q.oob  <= oob2_q;
      side3_q.fail <= fail2_q;
      side3_q.par  <= par2_q;
      side3_q.zero <= zero_c;
      side3_q.one  <= one_c;
    end
  end

  // ---------------- stage 4: squared length ----------------
  logic [RAD_W-1:0] rad4_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_DIV]) begin
      rad4_q <= {2'b00, sq3_q[0]} + {2'b00, sq3_q[1]} + {2'b00, sq3_q[2]};
    end
  end

  // ---------------- dividers and square root ----------------
  logic [COORD_W-1:0] quo [6];
  logic [ROOT_W-1:0]  root;

  for (genvar f = 0; f < 6; f++) begin : g_div
    rvil_div_pipe u_div (
      .clk_i (clk_i),
      .ld_i  (ld[S_DIV +: DIV_STEPS]),
      .num_i (numt3_q[f]),
      .den_i (den3_q[f/2]),
      .quo_o (quo[f])
    );
  end

  rvil_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .ld_i   (ld[S_SQRT +: SQRT_STEPS]),
    .rad_i  (rad4_q),
    .root_o (root)
  );

  side_t side_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (ld[S_DIV+j]) side_q[j] <= (j == 0) ? side3_q : side_q[(j == 0) ? 0 : j-1];
    end
  end

  // ---------------- entry and exit intersection ----------------
  side_t             sd;
  logic [FRAC_W-1:0] frac [6];
  logic [FRAC_W-1:0] mn [3];
  logic [FRAC_W-1:0] mx [3];
  logic [FRAC_W-1:0] lo_c, hi_c, lo_a, hi_a;
  logic [FRAC_W-1:0] lo36_q, hi36_q;
  logic              fail36_q, oob36_q;

  assign sd = side_q[DIV_STEPS-1];

  always_comb begin
    for (int f = 0; f < 6; f++) begin
      frac[f] = sd.zero[f] ? '0 : (sd.one[f] ? FRAC_ONE : {1'b0, quo[f]});
    end
    for (int a = 0; a < 3; a++) begin
      if (sd.par[a]) begin
        // no movement on this axis: it puts no bound on the overlap
        mn[a] = '0;
        mx[a] = FRAC_ONE;
      end else if (frac[2*a] < frac[2*a+1]) begin
        mn[a] = frac[2*a];
        mx[a] = frac[2*a+1];
      end else begin
        mn[a] = frac[2*a+1];
        mx[a] = frac[2*a];
      end
    end
    lo_a = (mn[0] > mn[1]) ? mn[0] : mn[1];
    hi_a = (mx[0] < mx[1]) ? mx[0] : mx[1];
    lo_c = (mn[2] > lo_a) ? mn[2] : lo_a;
    hi_c = (mx[2] < hi_a) ? mx[2] : hi_a;
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_LOHI]) begin
      lo36_q   <= lo_c;
      hi36_q   <= hi_c;
      fail36_q <= sd.fail;
      oob36_q  <= sd.oob;
    end
  end

  // ---------------- overlap width ----------------
  logic [FRAC_W-1:0] delta37_q;
  logic              fail37_q, oob37_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_DELTA]) begin
      delta37_q <= hi36_q - lo36_q;
      fail37_q  <= fail36_q || !(lo36_q < hi36_q);
      oob37_q   <= oob36_q;
    end
  end

  // ---------------- overlap times length ----------------
  logic [2*COORD_W-1:0] prod38_q;
  logic [ROOT_W-1:0]    root38_q;
  logic [COORD_W-1:0]   add38_q;
  logic                 full38_q, fail38_q, oob38_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_MUL]) begin
      prod38_q <= {{COORD_W{1'b0}}, delta37_q[COORD_W-1:0]} *
                  {{COORD_W{1'b0}}, root[COORD_W-1:0]};
      root38_q <= root;
      add38_q  <= root[ROOT_W-1] ? delta37_q[COORD_W-1:0] : '0;
      full38_q <= delta37_q[FRAC_W-1];
      fail38_q <= fail37_q;
      oob38_q  <= oob37_q;
    end
  end

  // ---------------- output register ----------------
  logic [ROOT_W-1:0] len_c;
  logic [LEN_W-1:0]  len39_q;
  status_e           stat39_q;

  assign len_c = full38_q ? root38_q
                          : ({1'b0, add38_q} + {1'b0, prod38_q[2*COORD_W-1:COORD_W]});

  always_ff @(posedge clk_i) begin
    if (ld[S_OUT]) begin
      if (oob38_q) begin
        len39_q  <= '0;
        stat39_q <= STAT_OOB;
      end else if (fail38_q) begin
        len39_q  <= '0;
        stat39_q <= STAT_MISS;
      end else begin
        // at most 33 bits, so the 40-bit ceiling is never reached
        len39_q  <= {{(LEN_W-ROOT_W){1'b0}}, len_c};
        stat39_q <= STAT_HIT;
      end
    end
  end

  assign segment_length_o = len39_q;
  assign status_o         = stat39_q;

endmodule

// File: hw/rtl/rvil_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, num below den
module rvil_div_pipe (
  input  logic                          clk_i,
  input  logic [rvil_pkg::DIV_STEPS-1:0] ld_i,
  input  logic [31:0]                   num_i,
  input  logic [31:0]                   den_i,
  output logic [31:0]                   quo_o
);
  import rvil_pkg::*;

  logic [31:0] rem_q [DIV_STEPS];
  logic [31:0] den_q [DIV_STEPS];
  logic [31:0] quo_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [31:0] rem_p, den_p, quo_p;
    logic [32:0] shf;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end

    assign shf = {rem_p, 1'b0};
    assign ge  = shf >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        rem_q[j] <= ge ? 32'(shf - {1'b0, den_p}) : shf[31:0];
        den_q[j] <= den_p;
        quo_q[j] <= {quo_p[30:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

// File: hw/rtl/rvil_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module rvil_sqrt_pipe (
  input  logic                              clk_i,
  input  logic [rvil_pkg::SQRT_STEPS-1:0]   ld_i,
  input  logic [rvil_pkg::RAD_W-1:0]        rad_i,
  output logic [rvil_pkg::ROOT_W-1:0]       root_o
);
  import rvil_pkg::*;

  logic [RAD_W-1:0]  val_q  [SQRT_STEPS];
  logic [34:0]       rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [RAD_W-1:0]  val_p;
    logic [34:0]       rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [34:0]       rem_t;
    logic [34:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign val_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign val_p  = val_q[j-1];
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
    end

    // the remainder never exceeds twice the root, so 33 bits hold it before the shift
    assign rem_t = {rem_p[32:0], val_p[RAD_W-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        val_q[j]  <= {val_p[RAD_W-3:0], 2'b00};
        rem_q[j]  <= ge ? (rem_t - trial) : rem_t;
        root_q[j] <= {root_p[ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule
